// ----- hdl/sms_pkg.sv -----
// Package for the stepper move sequencer: field widths, fixed-point constants,
// coil phase tables and the result word type. No dependencies.
package sms_pkg;

	localparam int DegW   = 12;
	localparam int CoilW  = 4;
	localparam int StepsW = 14;
	localparam int AngleW = 19;
	localparam int MarkW  = 20;
	localparam int FracW  = 7;

	// Opcodes of the command word.
	localparam logic OpTick  = 1'b0;
	localparam logic OpStart = 1'b1;

	// Angle grows per step by 90/128 degree (full) or 45/128 degree (half).
	localparam logic [AngleW-1:0] DeltaFull = AngleW'(90);
	localparam logic [AngleW-1:0] DeltaHalf = AngleW'(45);
	// Fifteen degrees in fixed point with seven fraction bits.
	localparam logic [MarkW-1:0]  MarkerStep = MarkW'(1920);

	// Step count is floor(512*m*deg/360) = floor((64*m*deg)/45).
	// The quotient by 45 is taken as a product with ceil(2^26/45); this is exact
	// for every dividend below 2^26/41, well above the largest, 4095*128.
	localparam int DivShift = 26;
	localparam int DivW     = 20;
	localparam int RecipW   = 21;
	localparam logic [RecipW-1:0] DivRecip = RecipW'(1491309);

	typedef struct packed {
		logic [CoilW-1:0] coil_pattern;
		logic             coil_valid;
		logic             report_valid;
		logic [DegW-1:0]  angle_report;
		logic             move_done;
	} sms_result_t;

	function automatic logic [CoilW-1:0] full_coil(input logic [1:0] idx);
		logic [CoilW-1:0] c;
		case (idx)
			2'd0:    c = 4'd1;
			2'd1:    c = 4'd2;
			2'd2:    c = 4'd4;
			default: c = 4'd8;
		endcase
		return c;
	endfunction

	function automatic logic [CoilW-1:0] half_coil(input logic [2:0] idx);
		logic [CoilW-1:0] c;
		case (idx)
			3'd0:    c = 4'd1;
			3'd1:    c = 4'd3;
			3'd2:    c = 4'd2;
			3'd3:    c = 4'd6;
			3'd4:    c = 4'd4;
			3'd5:    c = 4'd12;
			3'd6:    c = 4'd8;
			default: c = 4'd9;
		endcase
		return c;
	endfunction

endpackage

// ----- hdl/sms_if.sv -----
// Handshake channel interfaces for the stepper move sequencer: command words in,
// result words out. Depends on sms_pkg for field widths.
interface sms_cmd_if;
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic [sms_pkg::DegW-1:0] degrees;
	logic                     direction_ccw;
	logic                     half_step;

	modport source (output valid, opcode, degrees, direction_ccw, half_step, input ready);
	modport sink   (input valid, opcode, degrees, direction_ccw, half_step, output ready);
endinterface

interface sms_res_if;
	logic                      valid;
	logic                      ready;
	logic [sms_pkg::CoilW-1:0] coil_pattern;
	logic                      coil_valid;
	logic                      report_valid;
	logic [sms_pkg::DegW-1:0]  angle_report;
	logic                      move_done;

	modport source (output valid, coil_pattern, coil_valid, report_valid, angle_report,
		move_done, input ready);
	modport sink   (input valid, coil_pattern, coil_valid, report_valid, angle_report,
		move_done, output ready);
endinterface

// ----- hdl/stepper_move_sequencer_core.sv -----
// Top level of the stepper move sequencer: move state, phase sequencing and a
// four-word result queue. Depends on sms_pkg and the channel interfaces in sms_if.sv.

// The block takes one command word per clock cycle while its command side is ready
// and works it out in that same cycle: a start word loads the move, a tick word
// advances one coil phase and yields one result word, or two when a move closes
// short of the requested angle (the coil word, then a report-only word carrying the
// requested degrees). Result words leave through a four-word queue at one word per
// cycle while the sink is ready; the command side is ready whenever the queue holds
// two words or fewer, so with a free-running sink a command word is accepted every
// cycle, and each result word is registered in the queue before it reaches the
// output. The rate is set by the queue's single read port. Start words while a move
// runs and tick words while idle are dropped without a result; a start with zero
// degrees leaves the block idle with no result. The step count is formed with one
// 20 by 21 bit multiplication, combinationally in the accepting cycle.
module stepper_move_sequencer_core (
	input  logic             clk,
	input  logic             arst_n,
	sms_cmd_if.sink          cmd,
	sms_res_if.source        res
);
	import sms_pkg::*;

	localparam int QDepth = 4;
	localparam int QCntW  = $clog2(QDepth + 1);
	localparam int QIdxW  = $clog2(QDepth);

	// Move state.
	logic              busy_q;
	logic [StepsW-1:0] steps_left_q;
	logic [2:0]        phase_q;
	logic [AngleW-1:0] angle_q;
	logic [MarkW-1:0]  marker_q;
	logic [DegW-1:0]   target_q;
	logic              half_q;
	logic              reverse_q;

	// Result queue: entry zero is the head, the rest shift down on each pop.
	sms_result_t       queue_q [QDepth];
	logic [QCntW-1:0]  count_q;

	logic              accept;
	logic              is_tick;
	logic              is_start;

	// Phase and angle arithmetic for a tick.
	logic [2:0]        mask;
	logic [2:0]        p;
	logic [2:0]        idx;
	logic [CoilW-1:0]  coil;
	logic              step_end;
	logic [AngleW-1:0] angle_nx;
	logic [StepsW-1:0] steps_nx;
	logic              hit;
	logic              last;
	logic              short_move;

	// Step count for a start.
	logic [DivW-1:0]          dividend;
	logic [DivW+RecipW-1:0]   product;
	logic [StepsW-1:0]        steps_load;

	sms_result_t       r0;
	sms_result_t       r1;
	logic [1:0]        push_n;
	logic              pop;
	logic [QCntW-1:0]  base;

	assign cmd.ready = (count_q <= QCntW'(QDepth - 2));
	assign accept    = cmd.valid && cmd.ready;
	assign is_start  = accept && (cmd.opcode == OpStart) && !busy_q;
	assign is_tick   = accept && (cmd.opcode == OpTick) && busy_q;

	always_comb begin
		mask       = half_q ? 3'd7 : 3'd3;
		p          = phase_q & mask;
		// Counter-clockwise walks the table as (N - phase) mod N.
		idx        = reverse_q ? ((3'd0 - p) & mask) : p;
		coil       = half_q ? half_coil(idx) : full_coil(idx[1:0]);
		step_end   = (p == mask);
		angle_nx   = angle_q + (half_q ? DeltaHalf : DeltaFull);
		steps_nx   = steps_left_q - StepsW'(1);
		hit        = ({1'b0, angle_nx} >= marker_q);
		last       = step_end && (steps_nx == '0);
		short_move = (angle_nx < {target_q, FracW'(0)});
	end

	always_comb begin
		dividend   = cmd.half_step ? {1'b0, cmd.degrees, 7'd0} : {2'b0, cmd.degrees, 6'd0};
		product    = dividend * DivRecip;
		steps_load = product[DivShift +: StepsW];
	end

	// Result words of a tick.
	always_comb begin
		r0.coil_pattern = coil;
		r0.coil_valid   = 1'b1;
		r0.report_valid = step_end && hit;
		r0.angle_report = (step_end && hit) ? angle_nx[FracW +: DegW] : '0;
		r0.move_done    = last && !short_move;

		r1.coil_pattern = '0;
		r1.coil_valid   = 1'b0;
		r1.report_valid = 1'b1;
		r1.angle_report = target_q;
		r1.move_done    = 1'b1;

		if (!is_tick) begin
			push_n = 2'd0;
		end else if (last && short_move) begin
			push_n = 2'd2;
		end else begin
			push_n = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			steps_left_q <= '0;
			phase_q      <= '0;
			angle_q      <= '0;
			marker_q     <= MarkerStep;
			target_q     <= '0;
			half_q       <= 1'b0;
			reverse_q    <= 1'b0;
		end else if (is_start) begin
			reverse_q    <= cmd.direction_ccw;
			half_q       <= cmd.half_step;
			target_q     <= cmd.degrees;
			steps_left_q <= steps_load;
			phase_q      <= '0;
			angle_q      <= '0;
			marker_q     <= MarkerStep;
			busy_q       <= (steps_load != '0);
		end else if (is_tick) begin
			if (step_end) begin
				phase_q      <= '0;
				steps_left_q <= steps_nx;
				angle_q      <= angle_nx;
				if (hit) begin
					marker_q <= marker_q + MarkerStep;
				end
				if (steps_nx == '0) begin
					busy_q <= 1'b0;
				end
			end else begin
				phase_q <= p + 3'd1;
			end
		end
	end

	// Output queue.
	assign pop  = (count_q != '0) && res.ready;
	assign base = count_q - QCntW'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= base + QCntW'(push_n);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDepth; i++) begin
			if (QCntW'(i) < base) begin
				if (pop) begin
					queue_q[i] <= queue_q[(i + 1) % QDepth];
				end
			end else if ((QCntW'(i) == base) && (push_n != 2'd0)) begin
				queue_q[i] <= r0;
			end else if ((QCntW'(i) == base + QCntW'(1)) && (push_n == 2'd2)) begin
				queue_q[i] <= r1;
			end
		end
	end

	assign res.valid        = (count_q != '0);
	assign res.coil_pattern = queue_q[QIdxW'(0)].coil_pattern;
	assign res.coil_valid   = queue_q[QIdxW'(0)].coil_valid;
	assign res.report_valid = queue_q[QIdxW'(0)].report_valid;
	assign res.angle_report = queue_q[QIdxW'(0)].angle_report;
	assign res.move_done    = queue_q[QIdxW'(0)].move_done;

endmodule

// ----- hdl/sms_checker.sv -----
// Port-level checker for the stepper move sequencer and its bind to the top level.
// Depends on sms_pkg for field widths.
module sms_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [sms_pkg::CoilW-1:0] coil_pattern,
	input logic                      coil_valid,
	input logic                      report_valid,
	input logic [sms_pkg::DegW-1:0]  angle_report,
	input logic                      move_done
);
	import sms_pkg::*;

	// Every result word carries a coil phase, a report, or both.
	a_word_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (coil_valid || report_valid))
		else $error("result word with neither coil nor report");

	// A report-only word is always the closing word of a move.
	a_report_only_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !coil_valid) |-> move_done)
		else $error("report-only word without move_done");

	// Unused fields read as zero.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((coil_valid || (coil_pattern == '0)) &&
			(report_valid || (angle_report == '0))))
		else $error("unused result field not zero");

	// A phase word that closes a move is never followed by a report-only word.
	a_done_not_twice: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && coil_valid && move_done) |=>
			!(res_valid && !coil_valid))
		else $error("report-only word after a closing phase word");

	// A stalled word stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("result word withdrawn while stalled");

endmodule

bind stepper_move_sequencer_core sms_checker u_sms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.coil_pattern (res.coil_pattern),
	.coil_valid   (res.coil_valid),
	.report_valid (res.report_valid),
	.angle_report (res.angle_report),
	.move_done    (res.move_done)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for stepper_move_sequencer_core: a directed script, then random
// moves under three idling regimes. Depends on sms_pkg, the channel interfaces in sms_if.sv
// and the core itself.
module tb_top;
	import sms_pkg::*;

	// Cycles in a row with no word accepted on either channel before the run is abandoned.
	localparam int QuietLimit = 2000;
	// Cycles allowed for stray result words after the last expected one has arrived.
	localparam int DrainCycles = 20;

	localparam logic [CoilW-1:0] FullSeq [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
	localparam logic [CoilW-1:0] HalfSeq [8] = '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};

	// One command word as it is driven, plus an optional hand-written expectation.
	// A typed_n of -1 means the expectation comes from the motor model below.
	typedef struct {
		logic             opcode;
		logic [DegW-1:0]  degrees;
		logic             direction_ccw;
		logic             half_step;
		int               typed_n;
		sms_result_t      e0;
		sms_result_t      e1;
	} cmd_row_t;

	logic clk;
	logic arst_n;

	sms_cmd_if cmd ();
	sms_res_if res ();

	stepper_move_sequencer_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	// Words handed to the command channel and not yet accepted, in order of sending.
	cmd_row_t    staged_words[$];
	// Result words that the motor model says are still to come, oldest first.
	sms_result_t expected_words[$];

	int fail_count = 0;
	int quiet_cycles = 0;
	int src_idle_pct;
	int sink_idle_pct;

	// The testbench's own copy of the move state.
	logic              mv_busy;
	logic [StepsW-1:0] mv_steps;
	logic [2:0]        mv_phase;
	logic [AngleW-1:0] mv_angle;
	logic [MarkW-1:0]  mv_marker;
	logic [DegW-1:0]   mv_target;
	logic              mv_half;
	logic              mv_reverse;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic sms_result_t word_of(input logic [CoilW-1:0] coil, input logic cv,
		input logic rv, input logic [DegW-1:0] ang, input logic done);
		sms_result_t w;
		w.coil_pattern = coil;
		w.coil_valid   = cv;
		w.report_valid = rv;
		w.angle_report = ang;
		w.move_done    = done;
		return w;
	endfunction

	function automatic cmd_row_t plain_row(input logic op, input logic [DegW-1:0] deg,
		input logic ccw, input logic half);
		cmd_row_t r;
		r.opcode        = op;
		r.degrees       = deg;
		r.direction_ccw = ccw;
		r.half_step     = half;
		r.typed_n       = -1;
		r.e0            = '0;
		r.e1            = '0;
		return r;
	endfunction

	// A word of the given opcode whose other fields are random; the core must ignore them
	// on a tick, and on a start that arrives mid-move.
	function automatic cmd_row_t noise_row(input logic op);
		return plain_row(op, DegW'($urandom_range(4095)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endfunction

	// Number of tick words that a move needs to run to its end: steps times phases per step.
	function automatic int move_ticks(input int deg, input logic half);
		return ((512 * (half ? 2 : 1) * deg) / 360) * (half ? 8 : 4);
	endfunction

	// Motor model. It advances the move state for one accepted command word and queues the
	// result words that word should cause. Where the script row carries a hand-written
	// expectation, that is queued instead, but the state is still advanced.
	task automatic advance_motor(input cmd_row_t w);
		sms_result_t coil_word;
		sms_result_t short_word;
		int          n;
		int          slots;
		int          p;
		int          idx;
		n = 0;
		coil_word = '0;
		short_word = '0;
		if (w.opcode == OpStart) begin
			// A start is only taken while idle; it never produces a word of its own.
			if (!mv_busy) begin
				mv_target  = w.degrees;
				mv_reverse = w.direction_ccw;
				mv_half    = w.half_step;
				mv_steps   = StepsW'((512 * (w.half_step ? 2 : 1) * int'(w.degrees)) / 360);
				mv_phase   = '0;
				mv_angle   = '0;
				mv_marker  = MarkerStep;
				mv_busy    = (mv_steps != 0);
			end
		end else if (mv_busy) begin
			slots = mv_half ? 8 : 4;
			p = int'(mv_phase);
			// Counter-clockwise walks the phase table backwards from the same first entry.
			idx = mv_reverse ? (slots - p) % slots : p;
			coil_word = word_of(mv_half ? HalfSeq[idx] : FullSeq[idx], 1'b1, 1'b0, '0, 1'b0);
			n = 1;
			p = p + 1;
			if (p == slots) begin
				// The last phase of a step: one step done, the shaft angle moves on.
				p = 0;
				mv_steps = mv_steps - 1'b1;
				mv_angle = mv_angle + (mv_half ? DeltaHalf : DeltaFull);
				if (MarkW'(mv_angle) >= mv_marker) begin
					coil_word.report_valid = 1'b1;
					coil_word.angle_report = DegW'(mv_angle >> FracW);
					mv_marker = mv_marker + MarkerStep;
				end
				if (mv_steps == 0) begin
					mv_busy = 1'b0;
					// A move that stops short of the request closes with a report-only word;
					// otherwise the coil word itself carries the end of the move.
					if (mv_angle < {mv_target, FracW'(0)}) begin
						short_word = word_of('0, 1'b0, 1'b1, mv_target, 1'b1);
						n = 2;
					end else begin
						coil_word.move_done = 1'b1;
					end
				end
			end
			mv_phase = 3'(p);
		end
		if (w.typed_n >= 0) begin
			if (w.typed_n > 0)
				expected_words.push_back(w.e0);
			if (w.typed_n > 1)
				expected_words.push_back(w.e1);
		end else begin
			if (n > 0)
				expected_words.push_back(coil_word);
			if (n > 1)
				expected_words.push_back(short_word);
		end
	endtask

	// Compares one accepted result word, field by field, with the oldest expectation.
	task automatic compare_word(input sms_result_t got);
		sms_result_t want;
		if (expected_words.size() == 0) begin
			$error("result word with none expected: coil %0d report %0d angle %0d done %0d",
				got.coil_pattern, got.report_valid, got.angle_report, got.move_done);
			fail_count++;
		end else begin
			want = expected_words.pop_front();
			if (got.coil_pattern !== want.coil_pattern) begin
				$error("coil_pattern: expected %0d, got %0d", want.coil_pattern, got.coil_pattern);
				fail_count++;
			end
			if (got.coil_valid !== want.coil_valid) begin
				$error("coil_valid: expected %0d, got %0d", want.coil_valid, got.coil_valid);
				fail_count++;
			end
			if (got.report_valid !== want.report_valid) begin
				$error("report_valid: expected %0d, got %0d", want.report_valid, got.report_valid);
				fail_count++;
			end
			if (got.angle_report !== want.angle_report) begin
				$error("angle_report: expected %0d, got %0d", want.angle_report, got.angle_report);
				fail_count++;
			end
			if (got.move_done !== want.move_done) begin
				$error("move_done: expected %0d, got %0d", want.move_done, got.move_done);
				fail_count++;
			end
		end
	endtask

	// Both channels are observed at the rising edge, where the values seen are those held
	// through the cycle just ending. The command side is handled first: a word accepted at
	// this edge can only show up as a result at a later one.
	always @(posedge clk) begin
		sms_result_t got;
		if (!arst_n) begin
			mv_busy    = 1'b0;
			mv_steps   = '0;
			mv_phase   = '0;
			mv_angle   = '0;
			mv_marker  = MarkerStep;
			mv_target  = '0;
			mv_half    = 1'b0;
			mv_reverse = 1'b0;
		end else begin
			if (cmd.valid && cmd.ready)
				advance_motor(staged_words.pop_front());
			if (res.valid && res.ready) begin
				got.coil_pattern = res.coil_pattern;
				got.coil_valid   = res.coil_valid;
				got.report_valid = res.report_valid;
				got.angle_report = res.angle_report;
				got.move_done    = res.move_done;
				compare_word(got);
			end
			if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// The watchdog: a hung handshake or a result that never comes ends the run here.
	initial begin
		do @(posedge clk); while (quiet_cycles < QuietLimit);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// The result sink stalls at random, changing its mind on each falling edge.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			res.ready = arst_n && ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Drives one command word and returns at the falling edge after it has been taken.
	// Valid is held high from one word to the next unless the source chooses to idle, so
	// gaps fall wherever the random draw puts them, including between phases of a step.
	task automatic send_word(input cmd_row_t w);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd.valid = 1'b0;
			@(negedge clk);
		end
		staged_words.push_back(w);
		cmd.valid         = 1'b1;
		cmd.opcode        = w.opcode;
		cmd.degrees       = w.degrees;
		cmd.direction_ccw = w.direction_ccw;
		cmd.half_step     = w.half_step;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
	endtask

	// Random moves until at least the given number of words has gone in. Each move is a
	// start followed by exactly the ticks it needs, so that every move runs to its end and
	// the next start is taken. Mid-move starts and ticks while idle are mixed in as noise.
	// Half-step moves are kept short, since each of their steps costs eight ticks.
	task automatic run_moves(input int budget);
		int   sent;
		int   r;
		int   deg;
		int   ticks;
		logic half;
		logic ccw;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(99);
			half = 1'($urandom_range(1));
			ccw = 1'($urandom_range(1));
			if (r < 10) begin
				deg = 0;
			end else if (r < 60) begin
				deg = $urandom_range(1, 4);
			end else if (r < 85) begin
				deg = $urandom_range(5, 12);
			end else if (r < 97) begin
				// Long enough to pass the fifteen-degree mark, and for full step at 31 degrees or more the thirty.
				deg = half ? $urandom_range(16, 17) : $urandom_range(21, 32);
			end else begin
				// Forty-five degrees in full step lands exactly on the request and on a mark.
				half = 1'b0;
				deg = 45;
			end
			send_word(plain_row(OpStart, DegW'(deg), ccw, half));
			ticks = move_ticks(deg, half);
			sent += 1 + ticks;
			repeat (ticks) begin
				if ($urandom_range(99) < 4)
					send_word(noise_row(OpStart));
				send_word(noise_row(OpTick));
			end
			if ($urandom_range(99) < 25)
				repeat ($urandom_range(1, 3)) send_word(noise_row(OpTick));
		end
	endtask

	initial begin
		cmd_row_t script[$];
		cmd_row_t row;
		arst_n            = 1'b0;
		cmd.valid         = 1'b0;
		cmd.opcode        = OpTick;
		cmd.degrees       = '0;
		cmd.direction_ccw = 1'b0;
		cmd.half_step     = 1'b0;
		src_idle_pct      = 23;
		sink_idle_pct     = 54;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed script. Rows with a count carry their expectation in full; the rest are
		// left to the motor model.
		// A tick straight after reset finds the block idle and is dropped.
		row = plain_row(OpTick, '0, 1'b0, 1'b0);
		row.typed_n = 0;
		script.push_back(row);
		// Zero degrees loads no steps: nothing comes out and the block stays idle.
		row = plain_row(OpStart, '0, 1'b0, 1'b0);
		row.typed_n = 0;
		script.push_back(row);
		// One degree in full step is a single step.
		row = plain_row(OpStart, 12'd1, 1'b0, 1'b0);
		row.typed_n = 0;
		script.push_back(row);
		// A start during a move, with every field at its top value, is dropped.
		row = plain_row(OpStart, 12'd4095, 1'b1, 1'b1);
		row.typed_n = 0;
		script.push_back(row);
		for (int i = 0; i < 4; i++) begin
			row = plain_row(OpTick, '0, 1'b0, 1'b0);
			row.typed_n = 1;
			row.e0 = word_of(FullSeq[i], 1'b1, 1'b0, '0, 1'b0);
			script.push_back(row);
		end
		// The only step ends at 90/128 degree, short of one degree, so a report-only word
		// with the request closes the move and the coil word is not marked as the last.
		script[$].typed_n = 2;
		script[$].e1 = word_of('0, 1'b0, 1'b1, 12'd1, 1'b1);
		// One degree in half step, counter-clockwise: two steps of eight phases each.
		row = plain_row(OpStart, 12'd1, 1'b1, 1'b1);
		row.typed_n = 0;
		script.push_back(row);
		repeat (16) script.push_back(plain_row(OpTick, 12'd4095, 1'b1, 1'b1));
		foreach (script[i])
			send_word(script[i]);

		run_moves(120);
		src_idle_pct = 54;
		sink_idle_pct = 23;
		run_moves(120);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		run_moves(120);
		cmd.valid = 1'b0;

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- stepper_move_sequencer_core.f -----
hdl/sms_pkg.sv
hdl/sms_if.sv
hdl/stepper_move_sequencer_core.sv
hdl/sms_checker.sv
dv/tb_top.sv
